>>> rtl/gfi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfi_pkg
// Field constants and GF(2^10) arithmetic helpers shared by the inverter.
// ----------------------------------------------------------------------------
package gfi_pkg;

  localparam int          ElemW     = 10;
  localparam logic [10:0] FieldPoly = 11'h409;
  // square-and-multiply stages for a^(2^9 - 1)
  localparam int          NumStages = 8;

  typedef logic [ElemW-1:0] elem_t;

  // running power and the original element
  typedef struct packed {
    elem_t x;
    elem_t a;
  } stage_t;

  // reduce a degree <= 18 product modulo x^10 + x^3 + 1
  function automatic elem_t gf_reduce(input logic [2*ElemW-2:0] p);
    logic [2*ElemW-2:0] r;
    r = p;
    for (int i = 2*ElemW-2; i >= ElemW; i--) begin
      if (r[i]) begin
        r = r ^ ((2*ElemW-1)'(FieldPoly) << (i - ElemW));
      end
    end
    return r[ElemW-1:0];
  endfunction

  function automatic elem_t gf_mul(input elem_t a, input elem_t b);
    logic [2*ElemW-2:0] acc;
    acc = '0;
    for (int i = 0; i < ElemW; i++) begin
      if (b[i]) begin
        acc = acc ^ ((2*ElemW-1)'(a) << i);
      end
    end
    return gf_reduce(acc);
  endfunction

  // squaring spreads the bits, then reduces
  function automatic elem_t gf_sq(input elem_t a);
    logic [2*ElemW-2:0] s;
    s = '0;
    for (int i = 0; i < ElemW; i++) begin
      s[2*i] = a[i];
    end
    return gf_reduce(s);
  endfunction

endpackage

>>> rtl/gfi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfi_in_if / gfi_out_if
// Valid/ready channels carrying the element and its inverse.
// ----------------------------------------------------------------------------
interface gfi_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] element;
  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface gfi_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] inverse;
  modport source (output valid, output inverse, input ready);
  modport sink   (input valid, input inverse, output ready);
endinterface

>>> rtl/gfi_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfi_stage
// One pipeline stage: x <= x^2 * a, with its own valid bit and stall.
// ----------------------------------------------------------------------------
module gfi_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  gfi_pkg::stage_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output gfi_pkg::stage_t dn_data
);
  import gfi_pkg::*;

  logic   valid;
  stage_t data;
  stage_t data_next;

  // stage takes a new item when empty or when its item moves on
  assign up_ready = !valid || dn_ready;

  always_comb begin
    data_next.a = up_data.a;
    data_next.x = gf_mul(gf_sq(up_data.x), up_data.a);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

>>> rtl/gf1024_inverse_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf1024_inverse_top
// Multiplicative inverse in GF(2^10) modulo x^10 + x^3 + 1.
// ----------------------------------------------------------------------------
// The inverse is formed as a^1022 = (a^(2^9-1))^2: eight register stages each
// square the running power and multiply by the element, and the last square
// is taken at the output. A zero element gives zero. One item enters per
// cycle while the output is not stalled; each item passes through the eight
// stage registers in order, and the final square is combinational.
// Backpressure stalls the pipeline without loss; a stage with no item does
// not block the one before it.
module gf1024_inverse_top (
  input logic clk,
  input logic rst,
  gfi_in_if.sink    request,
  gfi_out_if.source result
);
  import gfi_pkg::*;

  logic   valid [NumStages+1];
  logic   ready [NumStages+1];
  stage_t data  [NumStages+1];

  // pipeline head: x starts as the element itself
  assign valid[0]      = request.valid;
  assign request.ready = ready[0];
  assign data[0].x     = request.element;
  assign data[0].a     = request.element;

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    gfi_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (valid[s]),
      .up_ready (ready[s]),
      .up_data  (data[s]),
      .dn_valid (valid[s+1]),
      .dn_ready (ready[s+1]),
      .dn_data  (data[s+1])
    );
  end

  // final squaring on the last stage register
  assign result.valid     = valid[NumStages];
  assign ready[NumStages] = result.ready;
  assign result.inverse   = gf_sq(data[NumStages].x);

endmodule

>>> sim/gf1024_inverse_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf1024_inverse_top_tb
// Self-checking bench for the GF(2^10) inverter. Elements are sent over the
// request channel with random gaps; each inverse is checked in order against
// an extended Euclid computed here, under random output stalls.
// ----------------------------------------------------------------------------
module gf1024_inverse_top_tb;
  import gfi_pkg::*;

  localparam int PolyMod   = 'h409;
  localparam int FieldDeg  = 10;
  localparam int RandItems = 750;
  localparam int CycleMax  = 200000;
  localparam int Drain     = 40;

  logic clk;
  logic rst;
  int   cycles;
  int   errors;
  int   items_sent;
  int   results_seen;
  logic no_idle;

  gfi_in_if  request ();
  gfi_out_if result ();

  gf1024_inverse_top dut (
    .clk    (clk),
    .rst    (rst),
    .request(request.sink),
    .result (result.source)
  );

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int poly_deg(input int p);
    int d;
    d = -1;
    for (int i = 0; i < 32; i++) if (p[i]) d = i;
    return d;
  endfunction

  // carry-less product, then fold back below degree ten
  function automatic int poly_mulmod(input int a, input int b);
    int acc;
    int d;
    acc = 0;
    for (int i = 0; i < 16; i++) if (b[i]) acc ^= a << i;
    d = poly_deg(acc);
    while (d >= FieldDeg) begin
      acc ^= PolyMod << (d - FieldDeg);
      d = poly_deg(acc);
    end
    return acc;
  endfunction

  // extended Euclid over GF(2)[x]; zero maps to zero
  function automatic elem_t field_inverse(input elem_t e);
    int r_old, r_new, t_old, t_new, quot, rem, dn, dr, t_next;
    r_old = PolyMod;
    r_new = int'(e);
    t_old = 0;
    t_new = 1;
    if (e == 0) return '0;
    for (int k = 0; k < 16 && r_new != 0; k++) begin
      quot = 0;
      rem  = r_old;
      dn   = poly_deg(r_new);
      dr   = poly_deg(rem);
      while (dr >= dn) begin
        quot ^= 1 << (dr - dn);
        rem  ^= r_new << (dr - dn);
        dr   = poly_deg(rem);
      end
      t_next = t_old ^ poly_mulmod(quot, t_new);
      r_old  = r_new;
      r_new  = rem;
      t_old  = t_new;
      t_new  = t_next;
    end
    return elem_t'(t_old);
  endfunction

  class inverse_scoreboard;
    elem_t pending_inv[$];
    elem_t pending_elem[$];

    function void note_element(input elem_t e);
      pending_elem.push_back(e);
      pending_inv.push_back(field_inverse(e));
    endfunction

    task check_inverse(input elem_t got);
      elem_t e;
      elem_t want;
      if (pending_inv.size() == 0) begin
        report_mismatch($sformatf("unexpected inverse %03h", got));
        return;
      end
      e    = pending_elem.pop_front();
      want = pending_inv.pop_front();
      if (got !== want)
        report_mismatch($sformatf("inverse of %03h: got %03h want %03h", e, got, want));
    endtask
  endclass

  inverse_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle count and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleMax) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // capture accepted inputs and results
  always @(posedge clk) begin
    if (!rst && request.valid && request.ready) begin
      sb.note_element(request.element);
      items_sent++;
    end
    if (!rst && result.valid && result.ready) begin
      sb.check_inverse(result.inverse);
      results_seen++;
    end
  end

  // receiver stalls about a quarter of the time, none during the no-idle stretch
  always @(posedge clk) begin
    if (rst) result.ready <= 1'b0;
    else     result.ready <= no_idle || ($urandom_range(99) >= 24);
  end

  task automatic send_element(input elem_t e);
    while (!no_idle && $urandom_range(99) < 24) begin
      request.valid <= 1'b0;
      @(posedge clk);
    end
    request.valid   <= 1'b1;
    request.element <= e;
    @(posedge clk);
    while (!request.ready) @(posedge clk);
  endtask

  initial begin
    elem_t directed[$];
    elem_t e;
    int    wait_cnt;
    sb              = new();
    cycles          = 0;
    errors          = 0;
    items_sent      = 0;
    results_seen    = 0;
    no_idle         = 1'b0;
    rst             = 1'b1;
    request.valid   = 1'b0;
    request.element = '0;
    result.ready    = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero, one, all ones, single bits and a few field-polynomial neighbors
    directed = '{10'h000, 10'h001, 10'h3FF, 10'h002, 10'h200, 10'h008, 10'h009,
                 10'h155, 10'h2AA, 10'h3FE, 10'h100, 10'h204, 10'h000, 10'h001};
    foreach (directed[i]) send_element(directed[i]);
    for (int b = 0; b < 10; b++) send_element(elem_t'(1 << b));

    for (int n = 0; n < RandItems; n++) begin
      no_idle = (n >= 300 && n < 420);
      e = elem_t'($urandom_range(1023));
      send_element(e);
    end
    no_idle = 1'b0;
    request.valid <= 1'b0;

    wait_cnt = 0;
    while (sb.pending_inv.size() != 0 && wait_cnt < 10000) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (sb.pending_inv.size() != 0) begin
      $display("Timeout with %0d inverses outstanding", sb.pending_inv.size());
      $display("Mismatches found");
      $finish;
    end
    repeat (Drain) @(posedge clk);

    $display("Covered %0d elements (zero, unit, single bits, random), %0d inverses checked",
             items_sent, results_seen);
    if (errors == 0 && sb.pending_inv.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/gfi_pkg.sv
rtl/gfi_if.sv
rtl/gfi_stage.sv
rtl/gf1024_inverse_top.sv
sim/gf1024_inverse_top_tb.sv
